@@ sv/cst_pkg.sv @@
// Shared types and constants of the character stream tokenizer.
// Used by cst_core, cst_fifo, char_stream_tokenizer and the testbench; depends on nothing.
package cst_pkg;

	localparam logic [15:0] POS_CAP    = 16'hFFFF;
	localparam int          FIFO_DEPTH = 4;
	localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int          FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [4:0] {
		KIND_END     = 5'd0,
		KIND_UNKNOWN = 5'd1,
		KIND_IDENT   = 5'd2,
		KIND_NUMBER  = 5'd3,
		KIND_LPAREN  = 5'd4,
		KIND_RPAREN  = 5'd5,
		KIND_LT      = 5'd6,
		KIND_GT      = 5'd7,
		KIND_MINUS   = 5'd8,
		KIND_PLUS    = 5'd9,
		KIND_STAR    = 5'd10,
		KIND_ASSIGN  = 5'd11,
		KIND_EQEQ    = 5'd12,
		KIND_COLON   = 5'd13,
		KIND_SEMI    = 5'd14,
		KIND_IF      = 5'd15,
		KIND_THEN    = 5'd16,
		KIND_ELSE    = 5'd17,
		KIND_DEF     = 5'd18
	} kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start_pos;
		logic [15:0] length;
		logic [15:0] row;
		logic [15:0] col;
		logic        last;
	} tok_t;

	// Up to two result beats produced by one item.
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       r0;
		tok_t       r1;
	} cst_wr_t;

endpackage

@@ sv/cst_core.sv @@
// Tokenizer state and the single-pass next-state and token logic.
// Depends on cst_pkg.
module cst_core import cst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     go,
	output cst_wr_t  wr
);

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_EQ   = 2'd1,
		PEND_NUM  = 2'd2,
		PEND_WORD = 2'd3
	} pend_t;

	localparam logic [7:0]  CH_TAB   = 8'h09;
	localparam logic [7:0]  CH_LF    = 8'h0A;
	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [7:0]  CH_EQ    = 8'h3D;
	localparam logic [7:0]  CH_US    = 8'h5F;
	localparam logic [31:0] KW_IF    = 32'h0000_6966;
	localparam logic [31:0] KW_THEN  = 32'h7468_656E;
	localparam logic [31:0] KW_ELSE  = 32'h656C_7365;
	localparam logic [31:0] KW_DEF   = 32'h0064_6566;

	pend_t       pend_q, pend_d;
	logic [15:0] tstart_q, tstart_d, trow_q, trow_d, tcol_q, tcol_d;
	logic [15:0] pos_q, pos_d, line_q, line_d, colc_q, colc_d;
	logic [31:0] prefix_q, prefix_d;
	logic [2:0]  wlen_q, wlen_d;

	function automatic logic [15:0] inc_sat(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h3C:   k = KIND_LT;
			8'h3E:   k = KIND_GT;
			8'h2D:   k = KIND_MINUS;
			8'h2B:   k = KIND_PLUS;
			8'h2A:   k = KIND_STAR;
			8'h3A:   k = KIND_COLON;
			8'h3B:   k = KIND_SEMI;
			default: k = KIND_END;
		endcase
		return k;
	endfunction

	logic [7:0]  c;
	logic        is_digit, is_wstart, is_wmore;
	logic [15:0] pos_inc, col_inc;
	kind_t       wkind, fkind, skind;
	logic        have_a, have_b;
	tok_t        res_a, res_b;

	always_comb begin
		c         = item.ch;
		is_digit  = c inside {[8'h30:8'h39]};
		is_wstart = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_US);
		is_wmore  = is_wstart || is_digit;
		pos_inc   = (pos_q < POS_CAP) ? pos_q + 16'd1 : pos_q;
		col_inc   = inc_sat(colc_q);
		skind     = single_kind(c);

		if (wlen_q == 3'd2 && prefix_q == KW_IF) begin
			wkind = KIND_IF;
		end else if (wlen_q == 3'd4 && prefix_q == KW_THEN) begin
			wkind = KIND_THEN;
		end else if (wlen_q == 3'd4 && prefix_q == KW_ELSE) begin
			wkind = KIND_ELSE;
		end else if (wlen_q == 3'd3 && prefix_q == KW_DEF) begin
			wkind = KIND_DEF;
		end else begin
			wkind = KIND_IDENT;
		end

		case (pend_q)
			PEND_EQ:   fkind = KIND_ASSIGN;
			PEND_NUM:  fkind = KIND_NUMBER;
			default:   fkind = wkind;
		endcase

		pend_d   = pend_q;
		tstart_d = tstart_q;
		trow_d   = trow_q;
		tcol_d   = tcol_q;
		pos_d    = pos_q;
		line_d   = line_q;
		colc_d   = colc_q;
		prefix_d = prefix_q;
		wlen_d   = wlen_q;

		have_a = 1'b0;
		have_b = 1'b0;
		res_a  = '{kind: fkind, start_pos: tstart_q, length: pos_q - tstart_q,
			row: trow_q, col: tcol_q, last: 1'b0};
		res_b  = '{kind: KIND_END, start_pos: pos_q, length: 16'd0,
			row: line_q, col: colc_q, last: 1'b1};

		if (item.end_of_text) begin
			have_a   = (pend_q != PEND_NONE);
			have_b   = 1'b1;
			pend_d   = PEND_NONE;
			tstart_d = 16'd0;
			trow_d   = 16'd1;
			tcol_d   = 16'd0;
			pos_d    = 16'd0;
			line_d   = 16'd1;
			colc_d   = 16'd0;
			prefix_d = 32'd0;
			wlen_d   = 3'd0;
		end else if (pend_q == PEND_EQ && c == CH_EQ) begin
			pos_d  = pos_inc;
			colc_d = col_inc;
			pend_d = PEND_NONE;
			have_b = 1'b1;
			res_b  = '{kind: KIND_EQEQ, start_pos: tstart_q, length: 16'd2,
				row: trow_q, col: tcol_q, last: 1'b1};
		end else if (pend_q == PEND_NUM && is_digit) begin
			pos_d  = pos_inc;
			colc_d = col_inc;
		end else if (pend_q == PEND_WORD && is_wmore) begin
			pos_d  = pos_inc;
			colc_d = col_inc;
			if (wlen_q < 3'd4) begin
				prefix_d = {prefix_q[23:0], c};
			end
			if (wlen_q < 3'd5) begin
				wlen_d = wlen_q + 3'd1;
			end
		end else begin
			have_a = (pend_q != PEND_NONE);
			pend_d = PEND_NONE;
			pos_d  = pos_inc;
			if (c == CH_SPACE || c == CH_TAB) begin
				colc_d = col_inc;
			end else if (c == CH_LF) begin
				line_d = inc_sat(line_q);
				colc_d = 16'd0;
			end else begin
				tstart_d = pos_q;
				trow_d   = line_q;
				tcol_d   = colc_q;
				colc_d   = col_inc;
				res_b    = '{kind: KIND_UNKNOWN, start_pos: pos_q, length: 16'd1,
					row: line_q, col: colc_q, last: 1'b1};
				if (skind != KIND_END) begin
					have_b     = 1'b1;
					res_b.kind = skind;
				end else if (c == CH_EQ) begin
					pend_d = PEND_EQ;
				end else if (is_digit) begin
					pend_d = PEND_NUM;
				end else if (is_wstart) begin
					pend_d   = PEND_WORD;
					prefix_d = {24'd0, c};
					wlen_d   = 3'd1;
				end else begin
					have_b = 1'b1;
				end
			end
		end

		res_a.last = !have_b;
		wr.cnt     = {1'b0, have_a} + {1'b0, have_b};
		wr.r0      = have_a ? res_a : res_b;
		wr.r1      = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= PEND_NONE;
			tstart_q <= 16'd0;
			trow_q   <= 16'd1;
			tcol_q   <= 16'd0;
			pos_q    <= 16'd0;
			line_q   <= 16'd1;
			colc_q   <= 16'd0;
			prefix_q <= 32'd0;
			wlen_q   <= 3'd0;
		end else if (go) begin
			pend_q   <= pend_d;
			tstart_q <= tstart_d;
			trow_q   <= trow_d;
			tcol_q   <= tcol_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			colc_q   <= colc_d;
			prefix_q <= prefix_d;
			wlen_q   <= wlen_d;
		end
	end

endmodule

@@ sv/cst_fifo.sv @@
// Small result queue that takes up to two token beats a cycle and gives one.
// Depends on cst_pkg.
module cst_fifo import cst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cst_wr_t            wr,
	input  logic               rd,
	output tok_t               rd_data,
	output logic [FIFO_CW-1:0] count
);

	tok_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0) begin
			mem_q[wp_q] <= wr.r0;
		end
		if (wr.cnt == 2'd2) begin
			mem_q[wp_q + FIFO_AW'(1)] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(wr.cnt);
			rp_q  <= rp_q + FIFO_AW'(rd);
			cnt_q <= cnt_q + FIFO_CW'(wr.cnt) - FIFO_CW'(rd);
		end
	end

	assign rd_data = mem_q[rp_q];
	assign count   = cnt_q;

endmodule

@@ sv/char_stream_tokenizer.sv @@
// Top level of the character stream tokenizer: input register, token logic and result queue.
// Depends on cst_pkg, cst_core and cst_fifo.
//
// One byte of text is taken per beat and one token is given per beat, each with its kind,
// start offset, length, row and column; the last token caused by an input beat has last set.
// An input beat is registered, and once the queue has room the token logic consumes it in a
// single pass and writes zero, one or two tokens into a four-entry result queue. A new byte is
// taken every cycle while the queue holds no more than two tokens; the output port gives one
// token per cycle while tok_ready is high, so bytes that yield two tokens at once slow the
// input only when they come in a dense run.
module char_stream_tokenizer import cst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     tok_valid,
	input  logic     tok_ready,
	output tok_t     tok
);

	in_item_t           item_s1;
	logic               valid_s1;
	logic               go;
	cst_wr_t            wr;
	logic [FIFO_CW-1:0] fifo_count;

	assign go         = valid_s1 && (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
	assign item_ready = !valid_s1 || go;
	assign tok_valid  = (fifo_count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	cst_wr_t wr_gated;

	always_comb begin
		wr_gated = wr;
		if (!go) begin
			wr_gated.cnt = 2'd0;
		end
	end

	cst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.go     (go),
		.wr     (wr)
	);

	cst_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr_gated),
		.rd      (tok_valid && tok_ready),
		.rd_data (tok),
		.count   (fifo_count)
	);

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue holds more beats than it has entries");

	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_s1.end_of_text |-> wr.cnt != 2'd0)
		else $error("end of text beat produced no token");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.kind == KIND_END |-> tok.last && tok.length == 16'd0)
		else $error("end of text token is not the last of its beat");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		go && wr.cnt == 2'd2 |-> !wr.r0.last && wr.r1.last)
		else $error("two tokens from one beat carry wrong last flags");

endmodule

@@ verif/tok_check_pkg.sv @@
`timescale 1ns / 100ps
// Token scoreboard for the character stream tokenizer testbench: a predictor of the token
// stream and a queue of the tokens still due. Depends on cst_pkg.
package tok_check_pkg;
	import cst_pkg::*;

	typedef enum logic [1:0] {
		OPEN_NONE,
		OPEN_EQ,
		OPEN_NUM,
		OPEN_WORD
	} open_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_US    = "_";

	class token_scoreboard;
		tok_t        tokens_due[$];
		tok_t        beat_toks[$];
		int unsigned errors;
		int unsigned beats;
		int unsigned tokens_seen;
		int unsigned texts;
		open_t       open_kind;
		logic [15:0] tok_start;
		logic [15:0] tok_row;
		logic [15:0] tok_col;
		logic [15:0] pos;
		logic [15:0] line_no;
		logic [15:0] col_no;
		logic [31:0] word_bytes;
		logic [2:0]  word_cnt;

		function new();
			restart();
		endfunction

		function void restart();
			open_kind  = OPEN_NONE;
			tok_start  = '0;
			tok_row    = 16'd1;
			tok_col    = '0;
			pos        = '0;
			line_no    = 16'd1;
			col_no     = '0;
			word_bytes = '0;
			word_cnt   = '0;
		endfunction

		static function logic [15:0] bump(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function void step_pos();
			if (pos < POS_CAP)
				pos = pos + 16'd1;
		endfunction

		static function logic is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		static function logic is_alpha(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
		endfunction

		static function kind_t op_kind(logic [7:0] c);
			case (c)
				"(": return KIND_LPAREN;
				")": return KIND_RPAREN;
				"<": return KIND_LT;
				">": return KIND_GT;
				"-": return KIND_MINUS;
				"+": return KIND_PLUS;
				"*": return KIND_STAR;
				":": return KIND_COLON;
				";": return KIND_SEMI;
				default: return KIND_END;
			endcase
		endfunction

		function void emit(kind_t k, logic [15:0] s, logic [15:0] n, logic [15:0] r,
				logic [15:0] c);
			tok_t t;
			t.kind      = k;
			t.start_pos = s;
			t.length    = n;
			t.row       = r;
			t.col       = c;
			t.last      = 1'b0;
			beat_toks.push_back(t);
		endfunction

		// Only the first four bytes of a word are kept, so longer words never match.
		function kind_t word_kind();
			if (word_cnt == 3'd2 && word_bytes == 32'h0000_6966)
				return KIND_IF;
			if (word_cnt == 3'd4 && word_bytes == 32'h7468_656E)
				return KIND_THEN;
			if (word_cnt == 3'd4 && word_bytes == 32'h656C_7365)
				return KIND_ELSE;
			if (word_cnt == 3'd3 && word_bytes == 32'h0064_6566)
				return KIND_DEF;
			return KIND_IDENT;
		endfunction

		function void close_open();
			kind_t k;
			if (open_kind == OPEN_NONE)
				return;
			case (open_kind)
				OPEN_EQ: begin
					k = KIND_ASSIGN;
				end
				OPEN_NUM: begin
					k = KIND_NUMBER;
				end
				default: begin
					k = word_kind();
				end
			endcase
			emit(k, tok_start, pos - tok_start, tok_row, tok_col);
			open_kind = OPEN_NONE;
		endfunction

		function void add_letter(logic [7:0] c);
			if (word_cnt < 3'd4)
				word_bytes = {word_bytes[23:0], c};
			if (word_cnt < 3'd5)
				word_cnt = word_cnt + 3'd1;
		endfunction

		function void start_fresh(logic [7:0] c);
			kind_t k;
			if (c == CH_SPACE || c == CH_TAB) begin
				step_pos();
				col_no = bump(col_no);
				return;
			end
			if (c == CH_NL) begin
				step_pos();
				line_no = bump(line_no);
				col_no  = '0;
				return;
			end
			tok_start = pos;
			tok_row   = line_no;
			tok_col   = col_no;
			step_pos();
			col_no = bump(col_no);
			k = op_kind(c);
			if (k != KIND_END) begin
				emit(k, tok_start, 16'd1, tok_row, tok_col);
			end else if (c == CH_EQ) begin
				open_kind = OPEN_EQ;
			end else if (is_digit(c)) begin
				open_kind = OPEN_NUM;
			end else if (is_alpha(c)) begin
				open_kind  = OPEN_WORD;
				word_bytes = '0;
				word_cnt   = '0;
				add_letter(c);
			end else begin
				emit(KIND_UNKNOWN, tok_start, 16'd1, tok_row, tok_col);
			end
		endfunction

		function void note_beat(in_item_t it);
			tok_t t;
			beats++;
			beat_toks.delete();
			if (it.end_of_text) begin
				close_open();
				emit(KIND_END, pos, 16'd0, line_no, col_no);
				restart();
				texts++;
			end else if (open_kind == OPEN_EQ && it.ch == CH_EQ) begin
				step_pos();
				col_no = bump(col_no);
				emit(KIND_EQEQ, tok_start, 16'd2, tok_row, tok_col);
				open_kind = OPEN_NONE;
			end else if (open_kind == OPEN_NUM && is_digit(it.ch)) begin
				step_pos();
				col_no = bump(col_no);
			end else if (open_kind == OPEN_WORD && (is_alpha(it.ch) || is_digit(it.ch))) begin
				step_pos();
				col_no = bump(col_no);
				add_letter(it.ch);
			end else begin
				close_open();
				start_fresh(it.ch);
			end
			foreach (beat_toks[i]) begin
				t      = beat_toks[i];
				t.last = (i == beat_toks.size() - 1);
				tokens_due.push_back(t);
			end
		endfunction

		function void cmp(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 40)
					$display("%0d ns: %s mismatch, expected %0d, got %0d", $time, field,
						want, got);
			end
		endfunction

		function void check_token(tok_t got);
			tok_t want;
			if (tokens_due.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0d ns: unexpected token, expected none, got kind %0d at %0d",
						$time, got.kind, got.start_pos);
				return;
			end
			want = tokens_due.pop_front();
			tokens_seen++;
			cmp("kind", 16'(want.kind), 16'(got.kind));
			cmp("start_pos", want.start_pos, got.start_pos);
			cmp("length", want.length, got.length);
			cmp("row", want.row, got.row);
			cmp("col", want.col, got.col);
			cmp("last", 16'(want.last), 16'(got.last));
		endfunction

		function int outstanding();
			return tokens_due.size();
		endfunction
	endclass

endpackage

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for char_stream_tokenizer: drives byte beats with random idling and checks
// every token against the scoreboard. Depends on cst_pkg, tok_check_pkg and the RTL.
module tb;
	import cst_pkg::*;
	import tok_check_pkg::*;

	logic     clk        = 1'b0;
	logic     arst_n     = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_ready;
	in_item_t item       = '0;
	logic     tok_valid;
	logic     tok_ready  = 1'b0;
	tok_t     tok;

	token_scoreboard sb;
	bit              idle_on       = 1'b1;
	bit              long_hold_req = 1'b0;
	string           word_pool[8]  = '{"if", "then", "else", "def", "thenx", "el", "define", "iff"};
	string           op_chars      = "()<>-+*:;=";
	string           ws_chars      = " \t\n";

	char_stream_tokenizer u_top (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.tok_valid,
		.tok_ready,
		.tok
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_item(in_item_t it);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_beat(it);
	endtask

	task automatic send_byte(logic [7:0] c);
		in_item_t it;
		it.ch          = c;
		it.end_of_text = 1'b0;
		send_item(it);
	endtask

	task automatic send_end();
		in_item_t it;
		it.ch          = 8'($urandom_range(0, 255));
		it.end_of_text = 1'b1;
		send_item(it);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] word_char(bit lead);
		int unsigned sel;
		sel = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
		if (sel < 26)
			return "a" + 8'(sel);
		if (sel < 52)
			return "A" + 8'(sel - 26);
		if (sel == 52)
			return "_";
		return "0" + 8'(sel - 53);
	endfunction

	// Mostly well-formed lexemes with random content, with some noise bytes and text ends.
	task automatic send_fragment();
		int unsigned n;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 18: begin
				if ($urandom_range(0, 1)) begin
					send_text(word_pool[$urandom_range(0, 7)]);
				end else begin
					n = $urandom_range(1, 8);
					send_byte(word_char(1'b1));
					repeat (n - 1) send_byte(word_char(1'b0));
				end
			end
			6, 7: begin
				n = $urandom_range(1, 5);
				repeat (n) send_byte("0" + 8'($urandom_range(0, 9)));
			end
			8, 9, 10: begin
				send_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
			end
			11, 12, 13, 14: begin
				n = $urandom_range(1, 3);
				repeat (n) send_byte(ws_chars[$urandom_range(0, 2)]);
			end
			15, 16: begin
				send_byte(8'($urandom_range(0, 255)));
			end
			17: begin
				send_end();
			end
			default: begin
				send_text("==");
			end
		endcase
	endtask

	initial begin
		int unsigned n;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				tok_ready <= 1'b0;
				repeat (120) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				tok_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			tok_ready <= 1'b1;
			@(posedge clk);
			if (tok_valid)
				sb.check_token(tok);
		end
	end

	initial begin
		int unsigned first;
		bit          hold_done;
		bit          drain_done;
		sb         = new();
		hold_done  = 1'b0;
		drain_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("if(def)_9<>-+*=:==;\t\n");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte("7");
		send_end();

		first = sb.beats;
		while (sb.beats < first + 340) begin
			if (!hold_done && sb.beats >= first + 120) begin
				long_hold_req = 1'b1;
				send_text("(;)+(;)+(;)+(;)+");
				hold_done = 1'b1;
			end
			if (!drain_done && sb.beats >= first + 230) begin
				wait_drained();
				drain_done = 1'b1;
			end
			send_fragment();
		end

		idle_on = 1'b0;
		first = sb.beats;
		while (sb.beats < first + 60)
			send_fragment();
		send_end();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d input beats over %0d texts, %0d tokens checked.", sb.beats,
			sb.texts, sb.tokens_seen);
		$display("Included an output hold-off that filled the queue, a full drain and a gapless tail.");
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Timed out with %0d tokens still due.", sb.outstanding());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
